FILE: rtl/lzssd_pkg.sv
package lzssd_pkg;

    // Bits in a literal token's payload.
    localparam int unsigned LIT_BITS = 8;

    // Token parse phase.
    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_LIT  = 2'd1,
        PH_POS  = 2'd2,
        PH_LEN  = 2'd3
    } phase_t;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_BITS = 6'b000010,
        ST_LIT  = 6'b000100,
        ST_RD   = 6'b001000,
        ST_WR   = 6'b010000,
        ST_END  = 6'b100000
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_byte;
        logic bit_step;
        logic rd_issue;
        logic emit_lit;
        logic emit_copy;
        logic emit_end;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic bits_left;  // unparsed bits remain in the held byte
        logic last_bit;   // the bit about to be stepped is the byte's last
        logic lit_done;   // stepping now completes a literal
        logic end_done;   // stepping now completes a zero position
        logic len_done;   // stepping now completes a length field
        logic copy_last;  // copy byte in hand is the final one
        logic out_free;   // output register can take a result this cycle
    } sts_t;

endpackage

FILE: rtl/lzssd_ctrl.sv
module lzssd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lzssd_pkg::sts_t sts,
    output lzssd_pkg::cmd_t cmd
);

    lzssd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lzssd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            lzssd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_byte = 1'b1;
                    state_next    = lzssd_pkg::ST_BITS;
                end
            end
            lzssd_pkg::ST_BITS: begin
                if (!sts.bits_left) begin
                    state_next = lzssd_pkg::ST_IDLE;
                end else begin
                    cmd.bit_step = 1'b1;
                    if (sts.lit_done) begin
                        state_next = lzssd_pkg::ST_LIT;
                    end else if (sts.end_done) begin
                        state_next = lzssd_pkg::ST_END;
                    end else if (sts.len_done) begin
                        state_next = lzssd_pkg::ST_RD;
                    end else if (sts.last_bit) begin
                        state_next = lzssd_pkg::ST_IDLE;
                    end
                end
            end
            lzssd_pkg::ST_LIT: begin
                if (sts.out_free) begin
                    cmd.emit_lit = 1'b1;
                    state_next   = lzssd_pkg::ST_BITS;
                end
            end
            lzssd_pkg::ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = lzssd_pkg::ST_WR;
            end
            lzssd_pkg::ST_WR: begin
                if (sts.out_free) begin
                    cmd.emit_copy = 1'b1;
                    state_next    = sts.copy_last ? lzssd_pkg::ST_BITS : lzssd_pkg::ST_RD;
                end
            end
            lzssd_pkg::ST_END: begin
                if (sts.out_free) begin
                    cmd.emit_end = 1'b1;
                    state_next   = lzssd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lzssd_pkg::ST_IDLE;
            end
        endcase
    end

    // At most one emission per cycle, and only into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_lit || cmd.emit_copy || cmd.emit_end) |-> sts.out_free)
        else $error("emission while output register busy");

    // A new byte is only taken when the previous one is fully parsed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !sts.bits_left)
        else $error("byte accepted with unparsed bits left");

    // A read is always followed by the write/emit step of the same copy byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |=> (state_reg == lzssd_pkg::ST_WR))
        else $error("window read not followed by copy step");

endmodule

FILE: rtl/lzssd_datapath.sv
module lzssd_datapath #(
    parameter int unsigned INDEX_BITS  = 13,
    parameter int unsigned LENGTH_BITS = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      s_tdata,
    input  lzssd_pkg::cmd_t cmd,
    output lzssd_pkg::sts_t sts,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    localparam int unsigned LEN_BIAS   = (1 + INDEX_BITS + LENGTH_BITS) / 9;
    localparam int unsigned WIN_DEPTH  = 1 << INDEX_BITS;
    localparam int unsigned GW         = $clog2(INDEX_BITS + 1);
    localparam int unsigned CW         = LENGTH_BITS + 1;

    logic [7:0]            win_mem [WIN_DEPTH];
    logic [7:0]            rd_data_reg;

    logic [7:0]            byte_reg,   byte_next;
    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    lzssd_pkg::phase_t     phase_reg,  phase_next;
    logic [GW-1:0]         gath_reg,   gath_next;
    logic [INDEX_BITS-1:0] field_reg,  field_next;
    logic [INDEX_BITS-1:0] match_reg,  match_next;
    logic [INDEX_BITS-1:0] wp_reg,     wp_next;
    logic [CW-1:0]         copy_left_reg, copy_left_next;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg,  out_byte_next;
    logic                  out_end_reg,   out_end_next;
    logic                  out_last_reg,  out_last_next;

    logic                  cur_bit;
    logic [INDEX_BITS-1:0] field_sh;
    logic [GW-1:0]         gath_inc;
    logic                  lit_hit, pos_hit, len_hit;
    logic                  win_we;
    logic [7:0]            win_wdata;

    assign cur_bit  = byte_reg[7];
    assign field_sh = {field_reg[INDEX_BITS-2:0], cur_bit};
    assign gath_inc = gath_reg + GW'(1);
    assign lit_hit  = (phase_reg == lzssd_pkg::PH_LIT) && (gath_inc == GW'(lzssd_pkg::LIT_BITS));
    assign pos_hit  = (phase_reg == lzssd_pkg::PH_POS) && (gath_inc == GW'(INDEX_BITS));
    assign len_hit  = (phase_reg == lzssd_pkg::PH_LEN) && (gath_inc == GW'(LENGTH_BITS));

    always_comb begin
        sts.bits_left = (bit_cnt_reg != 4'd0);
        sts.last_bit  = (bit_cnt_reg == 4'd1);
        sts.lit_done  = lit_hit;
        sts.end_done  = pos_hit && (field_sh == '0);
        sts.len_done  = len_hit;
        sts.copy_last = (copy_left_reg == '0);
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // Parse state.
    always_comb begin
        byte_next      = byte_reg;
        bit_cnt_next   = bit_cnt_reg;
        phase_next     = phase_reg;
        gath_next      = gath_reg;
        field_next     = field_reg;
        match_next     = match_reg;
        wp_next        = wp_reg;
        copy_left_next = copy_left_reg;

        if (cmd.load_byte) begin
            byte_next    = s_tdata;
            bit_cnt_next = 4'd8;
        end

        if (cmd.bit_step) begin
            byte_next    = {byte_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 4'd1;
            if (phase_reg == lzssd_pkg::PH_FLAG) begin
                phase_next = cur_bit ? lzssd_pkg::PH_LIT : lzssd_pkg::PH_POS;
                gath_next  = '0;
                field_next = '0;
            end else begin
                field_next = field_sh;
                gath_next  = gath_inc;
                if (lit_hit) begin
                    phase_next = lzssd_pkg::PH_FLAG;
                end else if (pos_hit) begin
                    match_next = field_sh;
                    phase_next = lzssd_pkg::PH_LEN;
                    gath_next  = '0;
                    field_next = '0;
                end else if (len_hit) begin
                    copy_left_next = CW'(field_sh[LENGTH_BITS-1:0]) + CW'(LEN_BIAS);
                    phase_next     = lzssd_pkg::PH_FLAG;
                end
            end
        end

        if (cmd.emit_lit) begin
            wp_next = wp_reg + INDEX_BITS'(1);
        end

        if (cmd.emit_copy) begin
            wp_next        = wp_reg + INDEX_BITS'(1);
            match_next     = match_reg + INDEX_BITS'(1);
            copy_left_next = copy_left_reg - CW'(1);
        end

        // End of stream: drop the rest of the byte and restart.
        if (cmd.emit_end) begin
            bit_cnt_next = 4'd0;
            phase_next   = lzssd_pkg::PH_FLAG;
            gath_next    = '0;
            field_next   = '0;
            match_next   = '0;
            wp_next      = INDEX_BITS'(1);
        end
    end

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit_lit) begin
            out_valid_next = 1'b1;
            out_byte_next  = field_reg[7:0];
            out_end_next   = 1'b0;
            out_last_next  = 1'b1;
        end else if (cmd.emit_copy) begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            out_end_next   = 1'b0;
            out_last_next  = (copy_left_reg == '0);
        end else if (cmd.emit_end) begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            out_end_next   = 1'b1;
            out_last_next  = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg   <= 4'd0;
            phase_reg     <= lzssd_pkg::PH_FLAG;
            gath_reg      <= '0;
            field_reg     <= '0;
            match_reg     <= '0;
            wp_reg        <= INDEX_BITS'(1);
            copy_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            bit_cnt_reg   <= bit_cnt_next;
            phase_reg     <= phase_next;
            gath_reg      <= gath_next;
            field_reg     <= field_next;
            match_reg     <= match_next;
            wp_reg        <= wp_next;
            copy_left_reg <= copy_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
        out_last_reg <= out_last_next;
    end

    // History window: one write port, one registered read port.
    assign win_we    = cmd.emit_lit || cmd.emit_copy;
    assign win_wdata = cmd.emit_lit ? field_reg[7:0] : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[wp_reg] <= win_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_data_reg <= win_mem[match_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    // A copy starts only after the length field closed the token.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (phase_reg == lzssd_pkg::PH_FLAG))
        else $error("window read outside a copy");

    // End marker carries a zero byte and closes the input byte's results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_end_reg) |-> (out_last_reg && (out_byte_reg == 8'd0)))
        else $error("malformed end marker");

    // After an end marker the parser is back at a flag bit with position 1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_end |=> ((phase_reg == lzssd_pkg::PH_FLAG) && (wp_reg == INDEX_BITS'(1))
                          && (bit_cnt_reg == 4'd0)))
        else $error("stream restart incomplete");

endmodule

FILE: rtl/lzss_stream_decoder.sv
// LZSS stream decoder. Compressed bytes enter one transfer at a time on the
// s_ side and are parsed most significant bit first: a 1 flag bit is
// followed by an 8-bit literal, a 0 flag bit by an INDEX_BITS absolute
// window position and a LENGTH_BITS length, which copies length+LEN_BIAS+1
// bytes (LEN_BIAS = (1+INDEX_BITS+LENGTH_BITS)/9, 2 at the default sizes)
// out of the 2^INDEX_BITS byte history window (copies may overlap the
// bytes they write). A zero position ends the stream: one transfer with
// tuser set and a zero byte is sent, the rest of that input byte is dropped,
// and decoding restarts at write position 1. tlast marks the final result
// transfer caused by an input byte; an input byte may cause none. The parser
// steps one bit per cycle when not sending: each accepted byte's bits are
// stepped in turn, a completed literal is sent in its own state, each copied
// byte takes a window read state and then a write-and-send state, and an end
// token sends its marker and skips the byte's remaining bits. Sends wait while
// the m_ side stalls. The window has one write port and one registered read
// port, so each copied byte is read before it is written and sent. The result
// sits in an output register, so the next byte is taken while the last result
// waits. Window contents are not cleared on reset or end of stream; copies
// must only reference bytes written since the stream began.
module lzss_stream_decoder #(
    parameter int unsigned INDEX_BITS  = 13,
    parameter int unsigned LENGTH_BITS = 4
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // last result of the input byte
    output logic       m_tuser    // [0] stream_end
);

    lzssd_pkg::cmd_t cmd;
    lzssd_pkg::sts_t sts;

    // Sequencer: bit parsing, literal/copy/end emission.
    lzssd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Bit parser, window memory and output register.
    lzssd_datapath #(
        .INDEX_BITS  (INDEX_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W       = 13;
    localparam int LEN_W       = 4;
    localparam int WIN         = 1 << IDX_W;
    localparam int LEN_BIAS    = (1 + IDX_W + LEN_W) / 9;
    localparam int FIRST_POS   = 1;     // write position at the start of a stream
    localparam int STALL_LIMIT = 4000;  // cycles without any transfer
    localparam int SHOW_LIMIT  = 30;    // mismatch lines printed at most
    localparam int TAIL_CYCLES = 80;    // one byte with a longest copy, plus margin

    // One decoded result as it should appear on the m_ side.
    typedef struct packed {
        logic [7:0] data;
        logic       eos;   // end-of-stream marker
        logic       tail;  // final result of its input byte
    } result_t;

    // One row of the directed script. fixed rows carry their result by hand
    // (none or one); the others are left to the decoder model.
    typedef struct packed {
        logic [7:0] din;
        logic       fixed;
        logic       has_out;
        logic [7:0] dout;
        logic       eos;
    } row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       m_tvalid;
    logic       m_tready = 1'b1;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;
    logic       m_tuser;            // [0] stream_end

    lzss_stream_decoder #(
        .INDEX_BITS (IDX_W),
        .LENGTH_BITS(LEN_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Directed script. Bit stream, MSB first:
    //   end token right after reset, trailing "11" dropped
    //   literals 0xFF, 0x00, 0xA5
    //   copy from 1, shortest length (FF 00 A5)
    //   copy from 6, longest length, overlapping its own output (18 x A5)
    //   literal 0x5A
    //   end token, trailing "01" dropped
    row_t directed_bytes [13] = '{
        '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // flag 0 and 7 position bits
        '{8'h03, 1'b1, 1'b1, 8'h00, 1'b1},  // zero position: end marker
        '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},  // literal not yet complete
        '{8'hC0, 1'b1, 1'b1, 8'hFF, 1'b0},
        '{8'h34, 1'b1, 1'b1, 8'h00, 1'b0},
        '{8'hA0, 1'b1, 1'b1, 8'hA5, 1'b0},
        '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},  // inside a position field
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},  // shortest copy
        '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hDF, 1'b0, 1'b0, 8'h00, 1'b0},  // longest copy, overlapped
        '{8'h5A, 1'b1, 1'b1, 8'h5A, 1'b0},
        '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h01, 1'b1, 1'b1, 8'h00, 1'b1}   // end marker, two bits dropped
    };

    //------------------------------------------------------------------
    // Decoder model: window, write pointer and token parser state.
    //------------------------------------------------------------------
    logic [7:0]        hist [WIN];
    logic [IDX_W-1:0]  wr_ptr = IDX_W'(FIRST_POS);
    lzssd_pkg::phase_t ph = lzssd_pkg::PH_FLAG;
    int unsigned       nbits;
    logic [IDX_W-1:0]  field_acc;
    logic [IDX_W-1:0]  copy_from;

    result_t produced[$];     // results of the byte just decoded
    result_t results_due[$];  // outstanding results, oldest first

    int errors     = 0;
    int bytes_sent = 0;

    function automatic void window_put(input logic [7:0] v);
        hist[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        produced.push_back('{data: v, eos: 1'b0, tail: 1'b0});
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int          k;
        int unsigned reps;
        logic        bitv;
        logic        dropped;
        logic [IDX_W-1:0] rd;
        result_t     r;
        produced.delete();
        dropped = 1'b0;
        for (k = 7; k >= 0 && !dropped; k--) begin
            bitv = b[k];
            if (ph == lzssd_pkg::PH_FLAG) begin
                ph = bitv ? lzssd_pkg::PH_LIT : lzssd_pkg::PH_POS;
                nbits = 0;
                field_acc = '0;
            end else begin
                field_acc = {field_acc[IDX_W-2:0], bitv};
                nbits++;
                case (ph)
                    lzssd_pkg::PH_LIT: if (nbits == lzssd_pkg::LIT_BITS) begin
                        window_put(field_acc[7:0]);
                        ph = lzssd_pkg::PH_FLAG;
                    end
                    lzssd_pkg::PH_POS: if (nbits == IDX_W) begin
                        if (field_acc == '0) begin
                            // end of stream: rest of this byte is discarded
                            produced.push_back('{data: 8'h00, eos: 1'b1, tail: 1'b0});
                            wr_ptr = IDX_W'(FIRST_POS);
                            ph = lzssd_pkg::PH_FLAG;
                            dropped = 1'b1;
                        end else begin
                            copy_from = field_acc;
                            ph = lzssd_pkg::PH_LEN;
                            nbits = 0;
                            field_acc = '0;
                        end
                    end
                    lzssd_pkg::PH_LEN: if (nbits == LEN_W) begin
                        reps = field_acc[LEN_W-1:0] + LEN_BIAS + 1;
                        rd = copy_from;
                        // byte by byte, so an overlapping copy sees its own output
                        repeat (reps) begin
                            window_put(hist[rd]);
                            rd = rd + 1'b1;
                        end
                        ph = lzssd_pkg::PH_FLAG;
                    end
                    default: ;
                endcase
            end
        end
        if (produced.size() != 0) begin
            r = produced.pop_back();
            r.tail = 1'b1;
            produced.push_back(r);
        end
    endfunction

    //------------------------------------------------------------------
    // Token generator. Tracks the write position and how many bytes the
    // current stream has written, so every copy reads written entries only.
    //------------------------------------------------------------------
    bit               bitq[$];
    logic [IDX_W-1:0] gen_wp   = IDX_W'(FIRST_POS);
    int               gen_fill = 0;

    function automatic void put_bits(input logic [31:0] v, input int w);
        for (int i = w - 1; i >= 0; i--) bitq.push_back(v[i]);
    endfunction

    function automatic void tok_literal(input logic [7:0] v);
        put_bits({1'b1, v}, 1 + lzssd_pkg::LIT_BITS);
        gen_wp = gen_wp + 1'b1;
        gen_fill++;
    endfunction

    // Copy from distance d behind the write position. Any d up to the bytes
    // written so far is safe, overlap included.
    function automatic void tok_random_copy(input int near, input bit longest);
        int dmax;
        int d;
        logic [IDX_W-1:0] pos;
        logic [LEN_W-1:0] len;
        dmax = (gen_fill < WIN) ? gen_fill : WIN - 1;
        if ($urandom_range(0, 9) < 3)
            d = $urandom_range(1, dmax);
        else
            d = $urandom_range(1, (dmax < near) ? dmax : near);
        pos = gen_wp - IDX_W'(d);
        if (pos == '0)
            pos = IDX_W'(FIRST_POS);  // only once the whole window is written
        len = longest ? {LEN_W{1'b1}} : LEN_W'($urandom_range(0, 15));
        put_bits({1'b0, pos, len}, 1 + IDX_W + LEN_W);
        gen_wp = gen_wp + IDX_W'(len + LEN_BIAS + 1);
        gen_fill += len + LEN_BIAS + 1;
    endfunction

    // End token, then random filler up to the byte boundary.
    function automatic void tok_stop();
        put_bits('0, 1 + IDX_W);
        while (bitq.size() % 8 != 0) bitq.push_back(1'($urandom_range(0, 1)));
        gen_wp = IDX_W'(FIRST_POS);
        gen_fill = 0;
    endfunction

    //------------------------------------------------------------------
    // s_ side
    //------------------------------------------------------------------
    bit calm          = 1'b0;  // no idling on either side
    bit sender_gappy  = 1'b1;
    bit receiver_gappy = 1'b1;

    // Called and returns at a falling edge; tvalid is left high so that a
    // following call can keep it up without a low blip.
    task automatic send_byte(input row_t row);
        int gap;
        if (!calm && sender_gappy && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.din;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(row.din);
        if (row.fixed) begin
            if (row.has_out)
                results_due.push_back('{data: row.dout, eos: row.eos, tail: 1'b1});
        end else begin
            foreach (produced[i]) results_due.push_back(produced[i]);
        end
        bytes_sent++;
        if (bytes_sent % 24 == 0) sender_gappy = ($urandom_range(0, 2) != 0);
        @(negedge aclk);
    endtask

    task automatic flush_bits();
        logic [7:0] b;
        row_t row;
        while (bitq.size() >= 8) begin
            for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
            row = '0;
            row.din = b;
            send_byte(row);
        end
    endtask

    // Mostly literals and copies; now and then an early end token.
    task automatic random_stream(input int n_tokens);
        int r;
        repeat (n_tokens) begin
            r = $urandom_range(0, 99);
            if (gen_fill == 0 || r < 40)
                tok_literal(r < 3 ? 8'h00 : r < 6 ? 8'hFF : 8'($urandom));
            else if (r < 96)
                tok_random_copy(20, 1'b0);
            else
                tok_stop();
            flush_bits();
        end
        tok_stop();
        flush_bits();
    endtask

    //------------------------------------------------------------------
    // m_ side: tready stalls in bursts
    //------------------------------------------------------------------
    int stall_left  = 0;
    int recv_cycles = 0;

    always @(negedge aclk) begin
        if (calm || !aresetn) begin
            m_tready <= 1'b1;
        end else begin
            if (stall_left == 0 && receiver_gappy && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
            recv_cycles++;
            if (recv_cycles % 64 == 0) receiver_gappy = ($urandom_range(0, 2) != 0);
        end
    end

    //------------------------------------------------------------------
    // Result check, one field at a time
    //------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t ns: result expected none actual byte %02h end %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = results_due.pop_front();
                check_field("out_byte", want.data, m_tdata);
                check_field("stream_end", {7'd0, want.eos}, {7'd0, m_tuser});
                check_field("last", {7'd0, want.tail}, {7'd0, m_tlast});
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, results_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        int base;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

        base = bytes_sent;
        while (bytes_sent - base < 50) random_stream($urandom_range(4, 30));

        // hold the sender until the decoder has drained completely
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (results_due.size() != 0) @(negedge aclk);

        base = bytes_sent;
        while (bytes_sent - base < 40) random_stream($urandom_range(4, 30));

        // last part runs without idling on either side
        calm = 1'b1;
        random_stream($urandom_range(8, 16));

        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
